@@ hw/rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned QDEPTH      = 2;
	localparam int unsigned QAW         = 1;
	localparam int unsigned MAX_OUT     = 8;
	localparam int unsigned NOTE_TRACKS = 8;

	typedef enum logic [1:0] {
		CMD_BUTTON,
		CMD_ROTARY,
		CMD_TICK,
		CMD_MIDI
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_KEY,
		KIND_MODE,
		KIND_TRACK,
		KIND_TICK,
		KIND_MIDI
	} kind_t;

	localparam logic [4:0] BTN_FIRST_STEP = 5'd1;
	localparam logic [4:0] BTN_LAST_STEP  = 5'd16;
	localparam logic [4:0] BTN_FIRST_LEN  = 5'd9;
	localparam logic [4:0] BTN_CLEAR      = 5'd20;
	localparam logic [4:0] KNOB_MODE      = 5'd1;
	localparam logic [4:0] KNOB_TRACK     = 5'd2;
	localparam logic [2:0] CONFIG_POS     = 3'd7;

	localparam logic [1:0] ST_OFF    = 2'd0;
	localparam logic [1:0] ST_ON     = 2'd1;
	localparam logic [1:0] ST_ACCENT = 2'd2;

	localparam logic [7:0] MIDI_STATUS_MASK = 8'hF0;
	localparam logic [7:0] MIDI_NOTE_ON     = 8'h90;
	localparam logic [6:0] VEL_ACCENT       = 7'd127;
	localparam logic [6:0] VEL_NORMAL       = 7'd100;

	localparam logic REG_TRACK_COUNT = 1'b0;
	localparam logic REG_TRACK_NOTES = 1'b1;

	localparam logic [3:0]  TRACK_COUNT_RESET = 4'd8;
	localparam logic [16:0] PULSE_RESET       = 17'd1000;

	localparam logic [16:0] PULSE_TABLE [8] = '{
		17'd1000, 17'd2000, 17'd3000, 17'd5000,
		17'd10000, 17'd20000, 17'd50000, 17'd100000
	};

	typedef struct packed {
		kind_t      kind;
		logic [4:0] button;
		logic [2:0] knob;
		logic [3:0] step;
		logic       fill;
		logic       accent_key;
		logic       option_key;
		logic [6:0] note;
		logic       vel_max;
	} evt_t;

	typedef struct packed {
		logic [2:0]  fire_track;
		logic        accent_pulse;
		logic        send_note;
		logic [6:0]  note_number;
		logic [6:0]  note_velocity;
		logic [16:0] pulse_micros;
		logic        last_of_run;
	} res_t;

endpackage

@@ hw/rtl/drum_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Event driven drum step sequencer with pattern store, edit keys and triggers.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are executed one at a time. A step tick
// reads one pattern row per cycle from the pattern store while the result
// side does not stall; a step key press goes through pop, row read, modify and
// write, every other item through pop and execute. A result waits in an
// output register while the next item is accepted. The pattern store keeps
// one valid flag per row, cleared at reset, so it is usable straight after
// reset and a clear-track press needs no pass over the row.
// Results: one per firing track or MIDI hit; tlast marks an item's last one.
module drum_step_sequencer
	import dss_pkg::*;
#(
	parameter int unsigned TRACKS   = 8,
	parameter int unsigned PATTERNS = 8,
	parameter int unsigned STEPS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [55:0]            cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// button, knob_value, step_index, fill_held, accent_held, option_key_held,
	// midi_status, midi_note, midi_velocity, zero padding
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// command
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// fire_track, accent_pulse, send_note, note_number, note_velocity,
	// pulse_micros, zero padding
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	logic push;
	evt_t push_data;
	logic full;
	logic q_valid;
	evt_t q_entry;
	logic q_pop;
	res_t res;

	dss_front #(
		.STEPS(STEPS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	dss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.valid    (q_valid),
		.data     (q_entry),
		.pop      (q_pop)
	);

	dss_back #(
		.TRACKS  (TRACKS),
		.PATTERNS(PATTERNS),
		.STEPS   (STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {4'b0000, res.pulse_micros, res.note_velocity, res.note_number,
		res.send_note, res.accent_pulse, res.fire_track};
	assign m_tlast = res.last_of_run;

endmodule

@@ hw/rtl/dss_ram.sv @@
// ----------------------------------------------------------------------------
// dss_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/dss_queue.sv @@
// ----------------------------------------------------------------------------
// dss_queue
// Two-entry event queue between the front and back halves.
// ----------------------------------------------------------------------------
module dss_queue
	import dss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t push_data,
	output logic full,
	output logic valid,
	output evt_t data,
	input  logic pop
);

	evt_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign valid   = (count_q != '0);
	assign data    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/dss_front.sv @@
// ----------------------------------------------------------------------------
// dss_front
// Input side: unpack items, classify them and drop those without effect.
// ----------------------------------------------------------------------------
module dss_front
	import dss_pkg::*;
#(
	parameter int unsigned STEPS = 16
) (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  push,
	output evt_t                  push_data,
	input  logic                  full
);

	logic [4:0] button;
	logic [3:0] step;
	logic [7:0] status;
	logic [6:0] vel;
	logic       keep;
	evt_t       evt;

	assign button = s_tdata[4:0];
	assign step   = s_tdata[11:8];
	assign status = s_tdata[22:15];
	assign vel    = s_tdata[36:30];

	always_comb begin
		evt            = '0;
		evt.button     = button;
		evt.knob       = s_tdata[7:5];
		evt.step       = step;
		evt.fill       = s_tdata[12];
		evt.accent_key = s_tdata[13];
		evt.option_key = s_tdata[14];
		evt.note       = s_tdata[29:23];
		evt.vel_max    = (vel == VEL_ACCENT);
		evt.kind       = KIND_KEY;
		keep           = 1'b0;
		case (cmd_t'(s_tuser))
			CMD_BUTTON: begin
				evt.kind = KIND_KEY;
				keep = (button >= BTN_FIRST_STEP && button <= BTN_LAST_STEP)
					|| button == BTN_CLEAR;
			end
			CMD_ROTARY: begin
				if (button == KNOB_MODE) begin
					evt.kind = KIND_MODE;
					keep = 1'b1;
				end else if (button == KNOB_TRACK) begin
					evt.kind = KIND_TRACK;
					keep = 1'b1;
				end
			end
			CMD_TICK: begin
				evt.kind = KIND_TICK;
				keep = (int'(step) < STEPS);
			end
			CMD_MIDI: begin
				evt.kind = KIND_MIDI;
				keep = ((status & MIDI_STATUS_MASK) == MIDI_NOTE_ON) && (vel != '0);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready  = !full;
	assign push      = s_tvalid && !full && keep;
	assign push_data = evt;

endmodule

@@ hw/rtl/dss_back.sv @@
// ----------------------------------------------------------------------------
// dss_back
// Execution side: pattern store, sequencer state, track scan and results.
// ----------------------------------------------------------------------------
module dss_back
	import dss_pkg::*;
#(
	parameter int unsigned TRACKS   = 8,
	parameter int unsigned PATTERNS = 8,
	parameter int unsigned STEPS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [55:0] cfg_data,
	input  logic        q_valid,
	input  evt_t        q_entry,
	output logic        q_pop,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int unsigned ROWS = PATTERNS * TRACKS;
	localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned PW   = $clog2(PATTERNS);
	localparam int unsigned TW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int unsigned TCW  = $clog2(TRACKS + 1);
	localparam int unsigned RW   = 2 * STEPS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_KEY_WR,
		S_SCAN
	} state_t;

	state_t          state_q;
	evt_t            cur_q;
	logic [3:0]      track_count_q;
	logic [55:0]     track_notes_q;
	logic [PW-1:0]   pattern_q;
	logic [TW-1:0]   edit_q;
	logic            cfg_mode_q;
	logic [16:0]     pulse_q;
	logic            row_ok_q [ROWS];
	logic [TCW-1:0]  rd_t_q;
	logic            ev_v_s1;
	logic [TW-1:0]   ev_t_s1;
	logic            ok_s1;
	logic            pend_v_q;
	logic [TW-1:0]   pend_t_q;
	logic            pend_acc_q;
	logic [3:0]      fire_cnt_q;
	logic            out_v_q;
	res_t            out_q;

	logic [TCW-1:0]  n;
	logic [PW-1:0]   pat;
	logic [3:0]      key_s;
	logic            key_step_ok;
	logic [AW-1:0]   key_addr;
	logic [AW-1:0]   scan_addr;
	logic [AW-1:0]   rd_addr;
	logic [RW-1:0]   rdata;
	logic [RW-1:0]   row;
	logic [RW-1:0]   new_row;
	logic [1:0]      tick_st;
	logic [1:0]      key_cur;
	logic [1:0]      key_new;
	logic            fire;
	logic            out_free;
	logic            stall;
	logic            issue;
	logic            scan_end;
	logic            midi_hit;
	logic [2:0]      midi_t;
	logic            ram_re;
	logic            ram_we;
	logic [6:0]      pend_note;
	logic            out_load;
	res_t            out_d;

	function automatic logic [6:0] note_of(input logic [55:0] notes, input logic [2:0] idx);
		return notes[7*idx +: 7];
	endfunction

	function automatic res_t make_res(input logic [2:0] trk, input logic acc,
			input logic [6:0] note, input logic [16:0] pulse, input logic last);
		res_t r;
		r.fire_track    = trk;
		r.accent_pulse  = acc;
		r.send_note     = (note != '0);
		r.note_number   = note;
		r.note_velocity = (note == '0) ? '0 : (acc ? VEL_ACCENT : VEL_NORMAL);
		r.pulse_micros  = pulse;
		r.last_of_run   = last;
		return r;
	endfunction

	dss_ram #(
		.WIDTH(RW),
		.DEPTH(ROWS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(key_addr),
		.wdata(new_row),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		if (int'(track_count_q) > TRACKS) begin
			n = TCW'(TRACKS);
		end else begin
			n = TCW'(track_count_q);
		end
	end

	assign pat         = cur_q.fill ? PW'(PATTERNS - 1) : pattern_q;
	assign key_s       = 4'(cur_q.button - BTN_FIRST_STEP);
	assign key_step_ok = cur_q.button >= BTN_FIRST_STEP && cur_q.button <= BTN_LAST_STEP
		&& int'(key_s) < STEPS;
	assign key_addr    = AW'(int'(pat) * TRACKS + int'(edit_q));
	assign scan_addr   = AW'(int'(pat) * TRACKS + int'(rd_t_q));
	assign rd_addr     = (state_q == S_SCAN) ? scan_addr : key_addr;

	assign row     = ok_s1 ? rdata : '0;
	assign tick_st = row[2*cur_q.step +: 2];
	assign key_cur = row[2*key_s +: 2];

	always_comb begin
		if (cur_q.accent_key) begin
			key_new = (key_cur == ST_ACCENT) ? ST_ON : ST_ACCENT;
		end else begin
			key_new = (key_cur == ST_OFF) ? ST_ON : ST_OFF;
		end
		new_row = (row & ~(RW'(3) << (2*key_s))) | (RW'(key_new) << (2*key_s));
	end

	assign out_free = !out_v_q || res_ready;
	assign fire     = (state_q == S_SCAN) && ev_v_s1 && (tick_st != ST_OFF)
		&& (fire_cnt_q < 4'(MAX_OUT));
	assign stall    = fire && pend_v_q && !out_free;
	assign issue    = (state_q == S_SCAN) && !stall && (rd_t_q < n);
	assign scan_end = (state_q == S_SCAN) && !ev_v_s1 && (rd_t_q >= n);

	always_comb begin
		midi_hit = 1'b0;
		midi_t   = '0;
		for (int i = NOTE_TRACKS - 1; i >= 0; i--) begin
			if (i < int'(n) && note_of(track_notes_q, 3'(i)) != '0
					&& note_of(track_notes_q, 3'(i)) == cur_q.note) begin
				midi_hit = 1'b1;
				midi_t   = 3'(i);
			end
		end
	end

	assign pend_note = (int'(pend_t_q) < NOTE_TRACKS) ?
		note_of(track_notes_q, 3'(pend_t_q)) : '0;

	assign ram_re = issue || (state_q == S_EXEC && cur_q.kind == KIND_KEY
		&& !cfg_mode_q && key_step_ok);
	assign ram_we = (state_q == S_KEY_WR);
	assign q_pop  = (state_q == S_IDLE) && q_valid;

	always_comb begin
		out_load = 1'b0;
		out_d    = make_res(3'(pend_t_q), pend_acc_q, pend_note, pulse_q, 1'b0);
		if (state_q == S_SCAN) begin
			if (fire && pend_v_q && out_free) begin
				out_load = 1'b1;
			end else if (scan_end && pend_v_q && out_free) begin
				out_load = 1'b1;
				out_d    = make_res(3'(pend_t_q), pend_acc_q, pend_note, pulse_q, 1'b1);
			end
		end else if (state_q == S_EXEC && cur_q.kind == KIND_MIDI && midi_hit && out_free) begin
			out_load = 1'b1;
			out_d    = make_res(midi_t, cur_q.vel_max, '0, pulse_q, 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			track_count_q <= TRACK_COUNT_RESET;
			track_notes_q <= '0;
			pattern_q     <= '0;
			edit_q        <= '0;
			cfg_mode_q    <= 1'b0;
			pulse_q       <= PULSE_RESET;
			for (int r = 0; r < ROWS; r++) begin
				row_ok_q[r] <= 1'b0;
			end
			rd_t_q        <= '0;
			ev_v_s1       <= 1'b0;
			ev_t_s1       <= '0;
			ok_s1         <= 1'b0;
			pend_v_q      <= 1'b0;
			pend_t_q      <= '0;
			pend_acc_q    <= 1'b0;
			fire_cnt_q    <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TRACK_COUNT) begin
					track_count_q <= cfg_data[3:0];
				end else begin
					track_notes_q <= cfg_data;
				end
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					case (cur_q.kind)
						KIND_KEY: begin
							if (cfg_mode_q) begin
								if (cur_q.option_key && cur_q.button >= BTN_FIRST_LEN
										&& cur_q.button <= BTN_LAST_STEP) begin
									pulse_q <= PULSE_TABLE[3'(cur_q.button - BTN_FIRST_LEN)];
								end
							end else if (key_step_ok) begin
								ok_s1   <= row_ok_q[key_addr];
								state_q <= S_KEY_WR;
							end else if (cur_q.button == BTN_CLEAR) begin
								row_ok_q[key_addr] <= 1'b0;
							end
						end
						KIND_MODE: begin
							if (cur_q.knob == CONFIG_POS) begin
								cfg_mode_q <= 1'b1;
							end else begin
								cfg_mode_q <= 1'b0;
								if (int'(cur_q.knob) < PATTERNS) begin
									pattern_q <= PW'(cur_q.knob);
								end else begin
									pattern_q <= PW'(PATTERNS - 1);
								end
							end
						end
						KIND_TRACK: begin
							if (int'(cur_q.knob) < int'(n)) begin
								edit_q <= TW'(cur_q.knob);
							end else if (n != '0) begin
								edit_q <= TW'(n - 1'b1);
							end else begin
								edit_q <= '0;
							end
						end
						KIND_TICK: begin
							rd_t_q     <= '0;
							ev_v_s1    <= 1'b0;
							pend_v_q   <= 1'b0;
							fire_cnt_q <= '0;
							state_q    <= S_SCAN;
						end
						KIND_MIDI: begin
							if (midi_hit && !out_free) begin
								state_q <= S_EXEC;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_KEY_WR: begin
					row_ok_q[key_addr] <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_SCAN: begin
					if (!stall) begin
						if (fire) begin
							pend_v_q   <= 1'b1;
							pend_t_q   <= ev_t_s1;
							pend_acc_q <= (tick_st == ST_ACCENT);
							fire_cnt_q <= fire_cnt_q + 1'b1;
						end
						ev_v_s1 <= issue;
						if (issue) begin
							ev_t_s1 <= TW'(rd_t_q);
							ok_s1   <= row_ok_q[scan_addr];
							rd_t_q  <= rd_t_q + 1'b1;
						end
					end
					if (scan_end && (!pend_v_q || out_free)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule
